FILE: src/arte_pkg.sv
// Shared types and constants of the alarm rule table engine.
// No dependencies.
package arte_pkg;

	localparam int RULE_SLOTS = 16;
	localparam int IDX_W      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int NUM_W      = 43;   // |dv| * 1000 fits in 43 bits
	localparam int DT_W       = 48;
	localparam int DIV_CNT_W  = $clog2(NUM_W);

	localparam logic [1:0] OP_UPSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_EVAL   = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [1:0] KIND_HIGH = 2'd0;
	localparam logic [1:0] KIND_LOW  = 2'd1;
	localparam logic [1:0] KIND_RATE = 2'd2;
	localparam logic [1:0] KIND_BAD  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_PARAM = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam logic [3:0]  MAX_PRIORITY = 4'd7;
	localparam logic [9:0]  MS_PER_S     = 10'd1000;
	localparam logic [31:0] Q_MAX        = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [31:0]        rule_id;
		logic [31:0]        point_key;
		logic [1:0]         alarm_kind;
		logic               rule_enabled;
		logic [3:0]         priority_req;
		logic signed [31:0] threshold;
		logic signed [31:0] hysteresis;
		logic signed [31:0] sample_value;
		logic [47:0]        time_ms;
	} req_t;

	typedef struct packed {
		logic               is_event;
		logic [1:0]         status;
		logic [31:0]        event_rule_id;
		logic [1:0]         event_kind;
		logic               raised;
		logic [2:0]         event_priority;
		logic signed [31:0] metric;
		logic signed [31:0] event_threshold;
		logic               last;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic idle;
		logic load;
		logic clear_all;
		logic track;
		logic next;
		logic prime_wr;
		logic fast_wr;
		logic div_start;
		logic rate_wr;
		logic emit;
		logic finish_wr;
		logic done_emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] op;
		logic       bad;
		logic       sel;
		logic       is_rate;
		logic       prime;
		logic       chg;
		logic       rchg;
		logic       last;
		logic       div_done;
		logic       out_free;
	} sts_t;

endpackage

FILE: src/alarm_rule_table_engine_core.sv
// Alarm rule table engine: one item in, its events and a completion item out.
// Upsert/remove scan slots until the rule id is hit or the last slot is reached;
// bad parameter or clear skip the scan; evaluate scans all 16 slots, one event per
// state change, plus the bit-serial divider (43 steps) per rate rule with history;
// a result stall holds the engine. One item at a time, taken only in the idle state.
// Reset (arst_n low) clears used, active and history flags of all 16 slots.
// Depends on arte_pkg, arte_ctrl, arte_dp.
module alarm_rule_table_engine_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  arte_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output arte_pkg::rsp_t rsp
);
	import arte_pkg::*;

	cmd_t cmd;
	sts_t sts;

	arte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	arte_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	assign req_stall = !cmd.idle;

endmodule

FILE: src/arte_div.sv
// Restoring divider, one quotient bit per cycle, for the rate metric.
// Depends on arte_pkg.
module arte_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [arte_pkg::NUM_W-1:0] dividend,
	input  logic [arte_pkg::DT_W-1:0]  divisor,
	output logic                      done,
	output logic [arte_pkg::NUM_W-1:0] quo,
	output logic [arte_pkg::DT_W-1:0]  rem
);
	import arte_pkg::*;

	logic [NUM_W-1:0]     quo_q;
	logic [DT_W-1:0]      rem_q;
	logic [DT_W-1:0]      dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DT_W:0]        shifted;
	logic [DT_W:0]        trial;
	logic                 ge;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[DT_W-1:0] : shifted[DT_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

FILE: src/arte_ctrl.sv
// Sequencer of the rule table engine: decodes an item and walks the slots.
// Depends on arte_pkg.
module arte_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  arte_pkg::sts_t sts,
	output arte_pkg::cmd_t cmd
);
	import arte_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_SCAN   = 8'b0000_0100,
		S_DIV    = 8'b0000_1000,
		S_RATE   = 8'b0001_0000,
		S_EMIT   = 8'b0010_0000,
		S_FINISH = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.op == OP_CLEAR) begin
					cmd.clear_all = 1'b1;
					state_d       = S_DONE;
				end else if (sts.bad) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.op != OP_EVAL) begin
					cmd.track = 1'b1;
					if (sts.sel || sts.last) begin
						state_d = S_FINISH;
					end else begin
						cmd.next = 1'b1;
					end
				end else if (sts.sel && sts.is_rate && !sts.prime) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else if (sts.sel && !sts.is_rate && sts.chg) begin
					cmd.fast_wr = 1'b1;
					state_d     = S_EMIT;
				end else begin
					cmd.prime_wr = sts.sel && sts.is_rate;
					if (sts.last) begin
						state_d = S_DONE;
					end else begin
						cmd.next = 1'b1;
					end
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_RATE;
				end
			end
			S_RATE: begin
				cmd.rate_wr = 1'b1;
				if (sts.rchg) begin
					state_d = S_EMIT;
				end else if (sts.last) begin
					state_d = S_DONE;
				end else begin
					cmd.next = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last) begin
						state_d = S_DONE;
					end else begin
						cmd.next = 1'b1;
						state_d  = S_SCAN;
					end
				end
			end
			S_FINISH: begin
				cmd.finish_wr = 1'b1;
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.done_emit = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/arte_dp.sv
// Datapath: rule table, slot scan index, comparisons, rate divider, result register.
// Depends on arte_pkg and arte_div.
module arte_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  arte_pkg::req_t req,
	input  arte_pkg::cmd_t cmd,
	output arte_pkg::sts_t sts,
	input  logic           rsp_stall,
	output logic           rsp_valid,
	output arte_pkg::rsp_t rsp
);
	import arte_pkg::*;

	logic [RULE_SLOTS-1:0] used_q;
	logic [RULE_SLOTS-1:0] active_q;
	logic [RULE_SLOTS-1:0] hp_q;
	logic [31:0]           rid_q   [RULE_SLOTS];
	logic [31:0]           pid_q   [RULE_SLOTS];
	logic [1:0]            kind_q  [RULE_SLOTS];
	logic                  en_q    [RULE_SLOTS];
	logic [2:0]            prio_q  [RULE_SLOTS];
	logic signed [31:0]    thr_q   [RULE_SLOTS];
	logic signed [31:0]    hys_q   [RULE_SLOTS];
	logic signed [31:0]    pval_q  [RULE_SLOTS];
	logic [47:0]           ptime_q [RULE_SLOTS];

	req_t             op_q;
	logic [IDX_W-1:0] idx_q;
	logic             hit_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q;
	rsp_t             ev_q;
	rsp_t             out_q;
	logic             out_valid_q;

	logic               act;
	logic signed [32:0] v33, thr33, hys33, t_lo, t_hi, prev33, dv33;
	logic [32:0]        absdv;
	logic [NUM_W-1:0]   num;
	logic [DT_W-1:0]    dt;
	logic               nxt_fast, nxt_rate, sat, frac;
	logic signed [32:0] m33;
	logic signed [31:0] m;
	logic               div_done;
	logic [NUM_W-1:0]   quo;
	logic [DT_W-1:0]    rem;
	logic               bad;
	logic [1:0]         status;
	logic [IDX_W-1:0]   wr_idx;
	logic               id_hit;

	assign act    = active_q[idx_q];
	assign v33    = {op_q.sample_value[31], op_q.sample_value};
	assign thr33  = {thr_q[idx_q][31], thr_q[idx_q]};
	assign hys33  = {hys_q[idx_q][31], hys_q[idx_q]};
	assign t_lo   = thr33 - hys33;
	assign t_hi   = thr33 + hys33;
	assign prev33 = {pval_q[idx_q][31], pval_q[idx_q]};
	assign dv33   = v33 - prev33;
	assign absdv  = dv33[32] ? 33'(-dv33) : 33'(dv33);
	assign num    = NUM_W'(absdv) * NUM_W'(MS_PER_S);
	assign dt     = op_q.time_ms - ptime_q[idx_q];

	always_comb begin
		if (kind_q[idx_q] == KIND_HIGH) begin
			nxt_fast = act ? (v33 > t_lo) : (v33 >= thr33);
		end else begin
			nxt_fast = act ? (v33 < t_hi) : (v33 <= thr33);
		end
	end

	arte_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num),
		.divisor  (dt),
		.done     (div_done),
		.quo      (quo),
		.rem      (rem)
	);

	assign sat      = quo >= NUM_W'(Q_MAX);
	assign m        = sat ? Q_MAX : {1'b0, quo[30:0]};
	assign frac     = !sat && (rem != '0);
	assign m33      = {1'b0, m};
	assign nxt_rate = act ? ((m33 > t_lo) || ((m33 == t_lo) && frac)) : (m33 >= thr33);

	assign id_hit = used_q[idx_q] && (rid_q[idx_q] == op_q.rule_id);

	always_comb begin
		unique case (op_q.opcode)
			OP_UPSERT: bad = (op_q.rule_id == '0) || (op_q.point_key == '0)
				|| op_q.hysteresis[31] || (op_q.priority_req > MAX_PRIORITY)
				|| (op_q.alarm_kind == KIND_BAD);
			OP_REMOVE: bad = op_q.rule_id == '0;
			OP_EVAL:   bad = op_q.point_key == '0;
			default:   bad = 1'b0;
		endcase
	end

	always_comb begin
		if (bad) begin
			status = ST_BAD_PARAM;
		end else if (op_q.opcode == OP_UPSERT) begin
			status = (hit_q || free_q) ? ST_OK : ST_FULL;
		end else if (op_q.opcode == OP_REMOVE) begin
			status = hit_q ? ST_OK : ST_NOT_FOUND;
		end else begin
			status = ST_OK;
		end
	end

	always_comb begin
		sts          = '0;
		sts.op       = op_q.opcode;
		sts.bad      = bad;
		sts.sel      = (op_q.opcode == OP_EVAL)
			? (used_q[idx_q] && en_q[idx_q] && (pid_q[idx_q] == op_q.point_key))
			: id_hit;
		sts.is_rate  = kind_q[idx_q] == KIND_RATE;
		sts.prime    = !hp_q[idx_q] || (op_q.time_ms <= ptime_q[idx_q]);
		sts.chg      = nxt_fast != act;
		sts.rchg     = nxt_rate != act;
		sts.last     = idx_q == IDX_W'(RULE_SLOTS - 1);
		sts.div_done = div_done;
		sts.out_free = !out_valid_q || !rsp_stall;
	end

	assign wr_idx = hit_q ? hit_idx_q : free_idx_q;

	// flag bits of the table and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			active_q    <= '0;
			hp_q        <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (cmd.next) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.track) begin
				if (id_hit) begin
					hit_q <= 1'b1;
				end else if (!used_q[idx_q] && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.clear_all) begin
				used_q   <= '0;
				active_q <= '0;
				hp_q     <= '0;
			end
			if (cmd.prime_wr) begin
				hp_q[idx_q] <= 1'b1;
			end
			if (cmd.fast_wr) begin
				active_q[idx_q] <= nxt_fast;
			end
			if (cmd.rate_wr) begin
				active_q[idx_q] <= nxt_rate;
			end
			if (cmd.finish_wr) begin
				if (op_q.opcode == OP_REMOVE) begin
					if (hit_q) begin
						used_q[hit_idx_q]   <= 1'b0;
						active_q[hit_idx_q] <= 1'b0;
						hp_q[hit_idx_q]     <= 1'b0;
					end
				end else if (!hit_q && free_q) begin
					used_q[free_idx_q]   <= 1'b1;
					active_q[free_idx_q] <= 1'b0;
					hp_q[free_idx_q]     <= 1'b0;
				end
			end
			if (cmd.emit || cmd.done_emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: table contents, latched item, event and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req;
		end
		if (cmd.track) begin
			if (id_hit) begin
				hit_idx_q <= idx_q;
			end else if (!used_q[idx_q] && !free_q) begin
				free_idx_q <= idx_q;
			end
		end
		if (cmd.prime_wr || cmd.rate_wr) begin
			pval_q[idx_q]  <= op_q.sample_value;
			ptime_q[idx_q] <= op_q.time_ms;
		end
		if (cmd.fast_wr || cmd.rate_wr) begin
			ev_q.is_event        <= 1'b1;
			ev_q.status          <= ST_OK;
			ev_q.event_rule_id   <= rid_q[idx_q];
			ev_q.event_kind      <= kind_q[idx_q];
			ev_q.raised          <= cmd.fast_wr ? nxt_fast : nxt_rate;
			ev_q.event_priority  <= prio_q[idx_q];
			ev_q.metric          <= cmd.fast_wr ? op_q.sample_value : m;
			ev_q.event_threshold <= thr_q[idx_q];
			ev_q.last            <= 1'b0;
		end
		if (cmd.finish_wr && (op_q.opcode == OP_UPSERT) && (hit_q || free_q)) begin
			rid_q[wr_idx]  <= op_q.rule_id;
			pid_q[wr_idx]  <= op_q.point_key;
			kind_q[wr_idx] <= op_q.alarm_kind;
			en_q[wr_idx]   <= op_q.rule_enabled;
			prio_q[wr_idx] <= op_q.priority_req[2:0];
			thr_q[wr_idx]  <= op_q.threshold;
			hys_q[wr_idx]  <= op_q.hysteresis;
		end
		if (cmd.emit) begin
			out_q <= ev_q;
		end else if (cmd.done_emit) begin
			out_q        <= '0;
			out_q.status <= status;
			out_q.last   <= 1'b1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
